// ===== src/rgb_to_hsv_range_threshold_assert.svh =====
// ============================================================================
// rgb_to_hsv_range_threshold_assert: assertion macros for the HSV threshold
// Short forms for the concurrent assertions of the checker.
// ============================================================================
`ifndef RGB_TO_HSV_RANGE_THRESHOLD_ASSERT_SVH
`define RGB_TO_HSV_RANGE_THRESHOLD_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define RHT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define RHT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rht_pkg.sv =====
// ============================================================================
// rht_pkg: shared types and constants of the HSV threshold
// Constants of the hue and saturation arithmetic, register indexes and the
// stage records of the pipeline.
// ============================================================================
package rht_pkg;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_HUE_LOW  = 3'd0;
   localparam logic [2:0] CSR_HUE_HIGH = 3'd1;
   localparam logic [2:0] CSR_SAT_LOW  = 3'd2;
   localparam logic [2:0] CSR_SAT_HIGH = 3'd3;
   localparam logic [2:0] CSR_VAL_LOW  = 3'd4;
   localparam logic [2:0] CSR_VAL_HIGH = 3'd5;

   // Reset values of the bounds.
   localparam logic [7:0] HUE_LOW_RST  = 8'd70;
   localparam logic [7:0] HUE_HIGH_RST = 8'd106;
   localparam logic [7:0] SAT_LOW_RST  = 8'd150;
   localparam logic [7:0] SAT_HIGH_RST = 8'd255;
   localparam logic [7:0] VAL_LOW_RST  = 8'd150;
   localparam logic [7:0] VAL_HIGH_RST = 8'd255;

   // Arithmetic constants.
   localparam logic [7:0] HUE_STEP   = 8'd42;
   localparam logic [7:0] HUE_BASE_R = 8'd0;
   localparam logic [7:0] HUE_BASE_G = 8'd84;
   localparam logic [7:0] HUE_BASE_B = 8'd170;
   localparam logic [7:0] HUE_SCALE  = 8'd180;
   localparam logic [7:0] FULL_SCALE = 8'd255;

   // Number of register stages from input to the output register.
   localparam int unsigned STAGES     = 8;
   localparam int unsigned DIV_STAGES = 4;

   typedef enum logic [1:0] {
      SEL_RED,
      SEL_GREEN,
      SEL_BLUE
   } sel_type;

   typedef struct packed {
      logic [7:0] v;
      logic [7:0] span;
      sel_type    sel;
      logic       neg;
      logic [7:0] mag;
   } sort_type;

   typedef struct packed {
      logic [15:0] rem;
      logic [7:0]  quo;
   } div_part_type;

   typedef struct packed {
      logic [7:0]   v;
      logic [7:0]   span;
      sel_type      sel;
      logic         neg;
      div_part_type sat;
      div_part_type hue;
   } div_type;

   typedef struct packed {
      logic [7:0]  v;
      logic [7:0]  s;
      logic [15:0] hue_prod;
   } fin_type;

endpackage

// ===== src/rgb_to_hsv_range_threshold.sv =====
// ============================================================================
// rgb_to_hsv_range_threshold: RGB pixel to HSV in-range mask, 8-stage pipe.
// A req word passes the 8 register stages before its rsp word is offered.
// Throughput: one pixel word per cycle while the output is not stalled;
// each of the 8 register stages holds one.
// Reset: synchronous; empties every stage and reloads the six default bounds.
// ============================================================================
//
// Pipeline:
//   stage 1  channel max/min, winning channel and hue difference magnitude
//   stage 2  numerators 255*span and 42*|diff|
//   stage 3-6  two restoring division steps per stage for both quotients
//   stage 7  saturation select, hue base plus signed quotient, times 180
//   stage 8  divide by 255 (reciprocal form) and the six bound compares
// Every stage carries a valid bit. A stage loads when it is empty or when the
// stage after it moves, so bubbles close up behind a stalled output word.
module rgb_to_hsv_range_threshold (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // chan_r [7:0], chan_g [15:8], chan_b [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // mask [7:0]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   // Bound registers.
   logic [7:0] hue_low_ff, hue_high_ff, sat_low_ff, sat_high_ff, val_low_ff, val_high_ff;

   // Stage valid bits and move enables.
   logic [rht_pkg::STAGES-1:0] vld_ff;
   logic [rht_pkg::STAGES-1:0] move;

   // Stage payloads.
   rht_pkg::sort_type st1_ff, st1_in;
   rht_pkg::div_type  st2_ff, st2_in;
   rht_pkg::div_type  dv_ff [rht_pkg::DIV_STAGES];
   rht_pkg::div_type  dv_in [rht_pkg::DIV_STAGES];
   rht_pkg::fin_type  st7_ff, st7_in;
   logic [7:0]        mask_ff, mask_in;

   // One restoring division step: subtract divisor << k when it fits.
   function automatic rht_pkg::div_part_type div_step(input rht_pkg::div_part_type x,
                                                      input logic [7:0] d,
                                                      input logic [2:0] k);
      logic [15:0]           trial;
      rht_pkg::div_part_type y;
      trial = 16'({8'd0, d} << k);
      y     = x;
      if (x.rem >= trial) begin
         y.rem    = x.rem - trial;
         y.quo[k] = 1'b1;
      end
      return y;
   endfunction

   // ---------------------------------------------------------------------------
   // Configuration writes. Indexes beyond the list are ignored.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff  <= rht_pkg::HUE_LOW_RST;
         hue_high_ff <= rht_pkg::HUE_HIGH_RST;
         sat_low_ff  <= rht_pkg::SAT_LOW_RST;
         sat_high_ff <= rht_pkg::SAT_HIGH_RST;
         val_low_ff  <= rht_pkg::VAL_LOW_RST;
         val_high_ff <= rht_pkg::VAL_HIGH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            rht_pkg::CSR_HUE_LOW:  hue_low_ff  <= csr_wdata;
            rht_pkg::CSR_HUE_HIGH: hue_high_ff <= csr_wdata;
            rht_pkg::CSR_SAT_LOW:  sat_low_ff  <= csr_wdata;
            rht_pkg::CSR_SAT_HIGH: sat_high_ff <= csr_wdata;
            rht_pkg::CSR_VAL_LOW:  val_low_ff  <= csr_wdata;
            rht_pkg::CSR_VAL_HIGH: val_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Flow control. The output stage moves when it is empty or its word is
   // taken; every earlier stage moves when it is empty or its successor moves.
   // ---------------------------------------------------------------------------
   always_comb begin
      move[rht_pkg::STAGES-1] = !vld_ff[rht_pkg::STAGES-1] || rsp_tready;
      for (int k = rht_pkg::STAGES - 2; k >= 0; k--) begin
         move[k] = !vld_ff[k] || move[k+1];
      end
   end

   assign req_tready = move[0];
   assign rsp_tvalid = vld_ff[rht_pkg::STAGES-1];
   assign rsp_tdata  = mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (move[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < rht_pkg::STAGES; k++) begin
            if (move[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: sort the channels. Ties go to red, then green, then blue. The
   // hue difference is kept as sign and magnitude for the unsigned divider.
   // ---------------------------------------------------------------------------
   always_comb begin
      logic [7:0] r, g, b, maxv, minv;
      logic [8:0] diff;
      r = req_tdata[7:0];
      g = req_tdata[15:8];
      b = req_tdata[23:16];
      maxv = (r >= g) ? ((r >= b) ? r : b) : ((g >= b) ? g : b);
      minv = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
      if (r >= g && r >= b) begin
         st1_in.sel = rht_pkg::SEL_RED;
         diff       = {1'b0, g} - {1'b0, b};
      end else if (g >= b) begin
         st1_in.sel = rht_pkg::SEL_GREEN;
         diff       = {1'b0, b} - {1'b0, r};
      end else begin
         st1_in.sel = rht_pkg::SEL_BLUE;
         diff       = {1'b0, r} - {1'b0, g};
      end
      st1_in.v    = maxv;
      st1_in.span = maxv - minv;
      st1_in.neg  = diff[8];
      st1_in.mag  = diff[8] ? 8'(9'd0 - diff) : diff[7:0];
   end

   // ---------------------------------------------------------------------------
   // Stage 2: numerators. 255*span is a shift and subtract.
   // ---------------------------------------------------------------------------
   always_comb begin
      st2_in.v        = st1_ff.v;
      st2_in.span     = st1_ff.span;
      st2_in.sel      = st1_ff.sel;
      st2_in.neg      = st1_ff.neg;
      st2_in.sat.rem  = {st1_ff.span, 8'd0} - 16'(st1_ff.span);
      st2_in.sat.quo  = '0;
      st2_in.hue.rem  = 16'(st1_ff.mag) * 16'(rht_pkg::HUE_STEP);
      st2_in.hue.quo  = '0;
   end

   // ---------------------------------------------------------------------------
   // Stages 3 to 6: both quotients fit in eight bits, two bits per stage,
   // most significant first. Saturation divides by max, hue by the span.
   // A zero divisor only occurs when the span is zero, which stage 7 masks.
   // ---------------------------------------------------------------------------
   always_comb begin
      for (int j = 0; j < rht_pkg::DIV_STAGES; j++) begin
         dv_in[j] = (j == 0) ? st2_ff : dv_ff[j-1];
         dv_in[j].sat = div_step(dv_in[j].sat, dv_in[j].v, 3'(7 - 2 * j));
         dv_in[j].sat = div_step(dv_in[j].sat, dv_in[j].v, 3'(6 - 2 * j));
         dv_in[j].hue = div_step(dv_in[j].hue, dv_in[j].span, 3'(7 - 2 * j));
         dv_in[j].hue = div_step(dv_in[j].hue, dv_in[j].span, 3'(6 - 2 * j));
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 7: saturation is zero exactly when the span is zero, and then the
   // hue is zero too. Otherwise the raw hue wraps to eight bits and is
   // multiplied by 180 ahead of the division by 255.
   // ---------------------------------------------------------------------------
   always_comb begin
      rht_pkg::div_type d;
      logic [7:0]       base, off, raw;
      logic             zero;
      d    = dv_ff[rht_pkg::DIV_STAGES-1];
      zero = (d.span == 8'd0);
      case (d.sel)
         rht_pkg::SEL_RED:   base = rht_pkg::HUE_BASE_R;
         rht_pkg::SEL_GREEN: base = rht_pkg::HUE_BASE_G;
         rht_pkg::SEL_BLUE:  base = rht_pkg::HUE_BASE_B;
         default:            base = rht_pkg::HUE_BASE_R;
      endcase
      off = d.neg ? (8'd0 - d.hue.quo) : d.hue.quo;
      raw = zero ? 8'd0 : (base + off);
      st7_in.v        = d.v;
      st7_in.s        = zero ? 8'd0 : d.sat.quo;
      st7_in.hue_prod = 16'(raw) * 16'(rht_pkg::HUE_SCALE);
   end

   // ---------------------------------------------------------------------------
   // Stage 8: floor(p / 255) = (p + (p >> 8) + 1) >> 8 for p below 65280,
   // then the inclusive bound checks.
   // ---------------------------------------------------------------------------
   always_comb begin
      logic [16:0] sum;
      logic [7:0]  h;
      logic        hit;
      sum = 17'(st7_ff.hue_prod) + 17'(st7_ff.hue_prod[15:8]) + 17'd1;
      h   = sum[15:8];
      hit = (h >= hue_low_ff) && (h <= hue_high_ff) &&
            (st7_ff.s >= sat_low_ff) && (st7_ff.s <= sat_high_ff) &&
            (st7_ff.v >= val_low_ff) && (st7_ff.v <= val_high_ff);
      mask_in = hit ? rht_pkg::FULL_SCALE : 8'd0;
   end

   // Payload registers need no reset; each loads when its stage moves.
   always_ff @(posedge clock) begin
      if (move[0]) begin
         st1_ff <= st1_in;
      end
      if (move[1]) begin
         st2_ff <= st2_in;
      end
      for (int j = 0; j < rht_pkg::DIV_STAGES; j++) begin
         if (move[j+2]) begin
            dv_ff[j] <= dv_in[j];
         end
      end
      if (move[rht_pkg::STAGES-2]) begin
         st7_ff <= st7_in;
      end
      if (move[rht_pkg::STAGES-1]) begin
         mask_ff <= mask_in;
      end
   end

endmodule

// ===== src/rht_checker.sv =====
// ============================================================================
// rht_checker: port checks of the HSV threshold
// Watches the stream ports of the top level and is bound to it below.
// ============================================================================
`include "rgb_to_hsv_range_threshold_assert.svh"

module rht_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   logic rsp_stall;
   logic mask_ok;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign mask_ok   = (rsp_tdata == 8'd0) || (rsp_tdata == 8'hFF);

   // A result word waiting on the output stays offered and holds its value.
   `RHT_ASSERT(a_rsp_hold_valid, clock, reset, rsp_stall |=> rsp_tvalid, "rsp valid dropped")
   `RHT_ASSERT(a_rsp_hold_data, clock, reset, rsp_stall |=> $stable(rsp_tdata), "rsp data moved")

   // The mask is all ones or all zeros.
   `RHT_ASSERT(a_mask_code, clock, reset, rsp_tvalid |-> mask_ok, "mask not 0 or 255")

   // With the output register empty the whole pipe can move, so input is taken.
   `RHT_ASSERT(a_ready_empty, clock, reset, !rsp_tvalid |-> req_tready, "empty but not ready")

   // Reset empties the pipeline.
   `RHT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "word right after reset")

endmodule

bind rgb_to_hsv_range_threshold rht_checker u_rht_checker (.*);

// ===== dv/tb_rgb_to_hsv_range_threshold.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_rgb_to_hsv_range_threshold: self-checking bench for the HSV threshold
// Drives RGB pixel words with random gaps and back pressure. A local HSV
// predictor computes the mask of every accepted word, and a checker compares
// each mask that leaves the block with the oldest predicted mask.
// ============================================================================
module tb_rgb_to_hsv_range_threshold;

   // Indexes past the last bound register. The block must ignore them.
   localparam logic [2:0] CSR_SPARE_6 = 3'd6;
   localparam logic [2:0] CSR_SPARE_7 = 3'd7;

   // The two mask values the block can produce.
   localparam logic [7:0] MASK_HIT  = 8'd255;
   localparam logic [7:0] MASK_MISS = 8'd0;

   // Signed working copies of the arithmetic constants for the predictor.
   localparam int K_HUE_STEP   = int'(rht_pkg::HUE_STEP);
   localparam int K_BASE_R     = int'(rht_pkg::HUE_BASE_R);
   localparam int K_BASE_G     = int'(rht_pkg::HUE_BASE_G);
   localparam int K_BASE_B     = int'(rht_pkg::HUE_BASE_B);
   localparam int K_HUE_SCALE  = int'(rht_pkg::HUE_SCALE);
   localparam int K_FULL_SCALE = int'(rht_pkg::FULL_SCALE);

   localparam int PIPE_DEPTH  = int'(rht_pkg::STAGES);  // register stages in the block
   localparam int CYCLE_LIMIT = 400000;  // far above the slowest correct run
   localparam int PHASE_WORDS = 200;     // random words per bound setting

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // chan_r [7:0], chan_g [15:8], chan_b [23:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // mask [7:0]
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   // Bench copy of the six bound registers, indexed by register index.
   logic [7:0] bound_reg [6] = '{rht_pkg::HUE_LOW_RST, rht_pkg::HUE_HIGH_RST,
                                 rht_pkg::SAT_LOW_RST, rht_pkg::SAT_HIGH_RST,
                                 rht_pkg::VAL_LOW_RST, rht_pkg::VAL_HIGH_RST};

   logic [7:0] mask_queue [$];    // predicted masks, oldest first
   int         error_count = 0;
   int         cycle_count = 0;
   bit         send_idle = 1'b0;  // sender draws gaps when set
   bit         recv_idle = 1'b0;  // receiver draws stalls when set
   int         hold_request = 0;  // one long receiver hold-off, in cycles

   rgb_to_hsv_range_threshold dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Watchdog. A hang anywhere in the flow ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d masks still pending",
                  cycle_count, mask_queue.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // HSV conversion and in-range test of one pixel under the current bounds.
   // V is the largest channel, S the spread scaled to 255 over V. The hue
   // base goes to the largest channel, red winning ties over green and green
   // over blue. The raw hue may go negative on the red side; it wraps to
   // eight bits before it is rescaled to the 0-180 range.
   function automatic logic [7:0] hsv_mask(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int               vmax;
      int               vmin;
      int               span;
      int               sat;
      int               raw;
      int               hue;
      rht_pkg::sel_type sel;
      vmax = (r >= g && r >= b) ? r : ((g >= b) ? g : b);
      vmin = (r <= g && r <= b) ? r : ((g <= b) ? g : b);
      if (r >= g && r >= b)
         sel = rht_pkg::SEL_RED;
      else if (g >= b)
         sel = rht_pkg::SEL_GREEN;
      else
         sel = rht_pkg::SEL_BLUE;
      span = vmax - vmin;
      sat  = (vmax == 0) ? 0 : (K_FULL_SCALE * span) / vmax;
      hue  = 0;
      if (sat != 0) begin
         // SystemVerilog int division truncates toward zero, as required.
         case (sel)
            rht_pkg::SEL_RED:
               raw = K_BASE_R + (K_HUE_STEP * (int'(g) - int'(b))) / span;
            rht_pkg::SEL_GREEN:
               raw = K_BASE_G + (K_HUE_STEP * (int'(b) - int'(r))) / span;
            default:
               raw = K_BASE_B + (K_HUE_STEP * (int'(r) - int'(g))) / span;
         endcase
         hue = ((raw & 255) * K_HUE_SCALE) / K_FULL_SCALE;
      end
      if (hue >= bound_reg[rht_pkg::CSR_HUE_LOW] && hue <= bound_reg[rht_pkg::CSR_HUE_HIGH] &&
          sat >= bound_reg[rht_pkg::CSR_SAT_LOW] && sat <= bound_reg[rht_pkg::CSR_SAT_HIGH] &&
          vmax >= bound_reg[rht_pkg::CSR_VAL_LOW] && vmax <= bound_reg[rht_pkg::CSR_VAL_HIGH])
         return MASK_HIT;
      return MASK_MISS;
   endfunction

   // Every accepted pixel word yields exactly one predicted mask.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         mask_queue.push_back(hsv_mask(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]));
   end

   // Every mask word leaving the block is matched against the oldest prediction.
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mask_queue.size() == 0) begin
            error_count <= error_count + 1;
            $display("%0t: mask word %0d arrived with nothing expected", $time,
                     rsp_tdata);
         end else begin
            want = mask_queue.pop_front();
            if (rsp_tdata !== want) begin
               error_count <= error_count + 1;
               $display("%0t: mask mismatch, expected %0d, actual %0d", $time,
                        want, rsp_tdata);
            end
         end
      end
   end

   // Receiver. Stalls a random number of cycles before each word when
   // recv_idle is set, and honors a single long hold-off when one is requested.
   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         if (hold_request > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end
         stall = recv_idle ? $urandom_range(0, 14) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Offers one pixel word and returns at the edge that accepts it. Valid
   // stays high into the next word when no gap is drawn.
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      int gap;
      gap = send_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {b, g, r};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drops valid after the last word of a test and waits for every mask.
   // Each word gives one mask, so an empty queue means the block is idle.
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (mask_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx <= rht_pkg::CSR_VAL_HIGH)
         bound_reg[idx] = value;
   endtask

   task automatic set_bounds(input logic [7:0] hl, input logic [7:0] hh,
                             input logic [7:0] sl, input logic [7:0] sh,
                             input logic [7:0] vl, input logic [7:0] vh);
      write_csr(rht_pkg::CSR_HUE_LOW, hl);
      write_csr(rht_pkg::CSR_HUE_HIGH, hh);
      write_csr(rht_pkg::CSR_SAT_LOW, sl);
      write_csr(rht_pkg::CSR_SAT_HIGH, sh);
      write_csr(rht_pkg::CSR_VAL_LOW, vl);
      write_csr(rht_pkg::CSR_VAL_HIGH, vh);
      csr_we <= 1'b0;
   endtask

   // Random pixel, packed {b, g, r}. Greys, pixels with two equal channels and
   // corner colors are mixed in with plain random pixels.
   function automatic logic [23:0] draw_pixel();
      logic [7:0] a;
      logic [7:0] c;
      a = 8'($urandom_range(0, 255));
      c = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0: return {a, a, a};
         1: return {c, a, a};
         2: return {a, c, a};
         3: return {a, a, c};
         4: return {8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
                    8'($urandom_range(0, 1) * 255)};
         default: return 24'($urandom());
      endcase
   endfunction

   // Default bounds straight out of reset: black, white, grey, primaries,
   // the three kinds of tie and a red hue that goes negative and wraps.
   task automatic test_reset_bounds();
      send_idle = 1'b1;
      recv_idle = 1'b1;
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd10);
      send_pixel(8'd0, 8'd200, 8'd180);
      send_pixel(8'd20, 8'd230, 8'd200);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      wait_results_drained();
   endtask

   // Register writes: fully open bounds, writes to spare indexes that must
   // change nothing, inverted bounds, and a hue window pinned at 180.
   task automatic test_csr_writes();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      set_bounds(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd10);
      wait_results_drained();
      write_csr(CSR_SPARE_6, 8'd255);
      write_csr(CSR_SPARE_7, 8'd0);
      csr_we <= 1'b0;
      send_pixel(8'd10, 8'd200, 8'd30);
      send_pixel(8'd90, 8'd90, 8'd90);
      wait_results_drained();
      set_bounds(8'd106, 8'd70, 8'd0, 8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      wait_results_drained();
      set_bounds(8'd180, 8'd180, 8'd0, 8'd255, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd10);
      wait_results_drained();
      set_bounds(8'd180, 8'd180, 8'd0, 8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd10);
      send_pixel(8'd255, 8'd0, 8'd1);
      wait_results_drained();
   endtask

   // Random pixels over a series of bound settings. The first two phases are
   // the extremes (everything passes, nothing passes); the rest draw windows
   // at random. Each phase runs a different mix of sender and receiver idling.
   task automatic test_random_phases();
      logic [23:0] px;
      logic [7:0]  lo [3];
      logic [7:0]  hi [3];
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 0) begin
            set_bounds(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
         end else if (phase == 1) begin
            set_bounds(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
         end else begin
            for (int k = 0; k < 3; k++) begin
               lo[k] = 8'($urandom_range(0, 160));
               hi[k] = 8'($urandom_range(32'(lo[k]), 255));
            end
            set_bounds(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
         end
         send_idle = phase[0];
         recv_idle = phase[1];
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // Short bursts without gaps inside the idling phases.
            if (phase >= 4 && n % 50 == 25) begin
               send_idle = ~send_idle;
               recv_idle = ~recv_idle;
            end
            px = draw_pixel();
            send_pixel(px[7:0], px[15:8], px[23:16]);
         end
         wait_results_drained();
      end
   endtask

   // The receiver holds off for a long stretch while the sender offers words
   // back to back, so the pipe fills and stalls the input side.
   task automatic test_backpressure();
      logic [23:0] px;
      set_bounds(8'd0, 8'd180, 8'd40, 8'd255, 8'd40, 8'd255);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      hold_request = 64;
      for (int n = 0; n < 50; n++) begin
         px = draw_pixel();
         send_pixel(px[7:0], px[15:8], px[23:16]);
      end
      wait_results_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_bounds();
      test_csr_writes();
      test_random_phases();
      test_backpressure();
      // Let any stray word come out before the verdict.
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (error_count == 0 && mask_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/rht_pkg.sv
src/rgb_to_hsv_range_threshold.sv
src/rht_checker.sv
dv/tb_rgb_to_hsv_range_threshold.sv
